/* rtl/core/voxel_cube_frame_buffer_defines.svh */
// ----------------------------------------------------------------------------
// voxel cube frame buffer assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef VOXEL_CUBE_FRAME_BUFFER_DEFINES_SVH
`define VOXEL_CUBE_FRAME_BUFFER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define VCFB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define VCFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/vcfb_pkg.sv */
// ----------------------------------------------------------------------------
// vcfb_pkg
// types and constants of the voxel cube frame buffer
// ----------------------------------------------------------------------------
package vcfb_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [2:0] {
      REQ_CLEAR = 3'd0,
      REQ_FILL  = 3'd1,
      REQ_SET   = 3'd2,
      REQ_CUBE  = 3'd3,
      REQ_SCAN  = 3'd4
   } vcfb_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_PT_RD,
      ST_RMW_WR,
      ST_SCAN,
      ST_SCAN_OUT
   } vcfb_state_type;

   // offset added to a corner coordinate for one wire cube point
   typedef enum logic [1:0] {
      OFF_ZERO,
      OFF_STEP,
      OFF_LAST
   } vcfb_off_type;

   typedef struct packed {
      vcfb_off_type x;
      vcfb_off_type y;
      vcfb_off_type z;
   } vcfb_edge_sel_type;

   localparam int unsigned EDGE_COUNT = 12;

   // which axis walks and which sits at the far corner, per cube edge
   function automatic vcfb_edge_sel_type edge_select(input logic [3:0] edge_idx);
      vcfb_edge_sel_type sel;
      case (edge_idx)
         4'd0:    sel = '{OFF_ZERO, OFF_STEP, OFF_ZERO};
         4'd1:    sel = '{OFF_STEP, OFF_ZERO, OFF_ZERO};
         4'd2:    sel = '{OFF_ZERO, OFF_ZERO, OFF_STEP};
         4'd3:    sel = '{OFF_LAST, OFF_STEP, OFF_LAST};
         4'd4:    sel = '{OFF_STEP, OFF_LAST, OFF_LAST};
         4'd5:    sel = '{OFF_LAST, OFF_LAST, OFF_STEP};
         4'd6:    sel = '{OFF_LAST, OFF_STEP, OFF_ZERO};
         4'd7:    sel = '{OFF_ZERO, OFF_STEP, OFF_LAST};
         4'd8:    sel = '{OFF_STEP, OFF_LAST, OFF_ZERO};
         4'd9:    sel = '{OFF_STEP, OFF_ZERO, OFF_LAST};
         4'd10:   sel = '{OFF_LAST, OFF_ZERO, OFF_STEP};
         default: sel = '{OFF_ZERO, OFF_LAST, OFF_STEP};
      endcase
      return sel;
   endfunction

   function automatic logic [4:0] off_value(input vcfb_off_type sel,
                                            input logic [4:0] step,
                                            input logic [4:0] last);
      logic [4:0] v;
      case (sel)
         OFF_STEP: v = step;
         OFF_LAST: v = last;
         default:  v = 5'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/voxel_cube_frame_buffer.sv */
// ----------------------------------------------------------------------------
// voxel_cube_frame_buffer
// frame buffer of an led cube held in a 64 x 8 synchronous ram, one byte per
// (layer z, row y), read-modify-write for voxel and wire cube drawing
// after a transfer: clear leaves the block ready, fill writes SIDE*SIDE rows,
// set voxel and wire cube (12*edge_len points) read then write each point in range,
// scan makes 8 ram reads to the rsp register and waits while a result is held
// reset: store reads as zero at once through per-entry valid flops, no sweep
// ----------------------------------------------------------------------------
module voxel_cube_frame_buffer
   import vcfb_pkg::*;
#(
   parameter int SIDE = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pos_x[4:0], pos_y[9:5], pos_z[14:10],
                                    // edge_len[19:15], layer[22:20], zero pad
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // layer_select[7:0], layer_bits[71:8]
);

   // all in-range bits of a row set
   localparam logic [7:0] FILL_MASK = 8'(8'hff >> (8 - SIDE));

   vcfb_state_type state_ff, state_in;

   // request fields held for the whole operation
   logic [4:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [4:0] edge_len_ff;
   logic [2:0] layer_ff;
   logic       cube_ff;

   // wire cube walk counters
   logic [4:0] edge_step_ff;
   logic [3:0] edge_index_ff;

   // entry address under work, bit within the row byte
   logic [5:0] addr_ff;
   logic [2:0] bit_ff;

   // scan read counter and gathered layer
   logic [3:0]  scan_cnt_ff;
   logic [63:0] scan_bits_ff;

   // result register
   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff;

   // voxel ram and its entry valid flags (flag clear reads as zero)
   logic [7:0]  store_mem [0:63];
   logic [63:0] valid_ff;
   logic [7:0]  rdata_ff;
   logic        rd_valid_ff;
   logic [7:0]  rd_byte;

   logic       mem_rd_en;
   logic [5:0] mem_rd_addr;
   logic       mem_we;
   logic [5:0] mem_wr_addr;
   logic [7:0] mem_wdata;

   logic         req_xfer;
   vcfb_req_type req_kind;

   // point under work
   vcfb_edge_sel_type pt_sel;
   logic [4:0]        edge_last;
   logic signed [6:0] pt_x, pt_y, pt_z;
   logic              pt_in_range;
   logic [5:0]        pt_addr;
   logic              point_done;
   logic              last_point;
   logic              fill_last;
   logic              rsp_free;

   assign req_xfer = req_tvalid && req_tready;
   assign req_kind = vcfb_req_type'(req_tuser);
   assign rd_byte  = rd_valid_ff ? rdata_ff : 8'h00;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------------
   // point address: corner plus per-axis offset, each point clipped alone
   // ---------------------------------------------------------------------
   assign edge_last = edge_len_ff - 5'd1;

   always_comb begin
      if (cube_ff) begin
         pt_sel = edge_select(edge_index_ff);
      end else begin
         pt_sel = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
      end
   end

   assign pt_x = $signed({{2{pos_x_ff[4]}}, pos_x_ff})
               + $signed({2'b00, off_value(pt_sel.x, edge_step_ff, edge_last)});
   assign pt_y = $signed({{2{pos_y_ff[4]}}, pos_y_ff})
               + $signed({2'b00, off_value(pt_sel.y, edge_step_ff, edge_last)});
   assign pt_z = $signed({{2{pos_z_ff[4]}}, pos_z_ff})
               + $signed({2'b00, off_value(pt_sel.z, edge_step_ff, edge_last)});

   assign pt_in_range = !pt_x[6] && (pt_x[5:0] < 6'(SIDE))
                     && !pt_y[6] && (pt_y[5:0] < 6'(SIDE))
                     && !pt_z[6] && (pt_z[5:0] < 6'(SIDE));
   assign pt_addr = {pt_z[2:0], pt_y[2:0]};

   // a single voxel is a walk of one point
   assign last_point = !cube_ff
                    || ((edge_index_ff == 4'(EDGE_COUNT - 1)) && (edge_step_ff == edge_last));

   assign fill_last = (addr_ff[5:3] == 3'(SIDE - 1)) && (addr_ff[2:0] == 3'(SIDE - 1));

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_kind)
                  REQ_FILL: state_in = ST_FILL;
                  REQ_SET:  state_in = ST_PT_RD;
                  REQ_CUBE: state_in = (req_tdata[19:15] != 5'd0) ? ST_PT_RD : ST_IDLE;
                  REQ_SCAN: state_in = ST_SCAN;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            if (fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_PT_RD: begin
            if (pt_in_range) begin
               state_in = ST_RMW_WR;
            end else if (last_point) begin
               state_in = ST_IDLE;
            end
         end
         ST_RMW_WR: begin
            state_in = last_point ? ST_IDLE : ST_PT_RD;
         end
         ST_SCAN: begin
            if (scan_cnt_ff[3]) begin
               state_in = ST_SCAN_OUT;
            end
         end
         ST_SCAN_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // outputs of the sequencer: ram port controls
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready  = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = pt_addr;
      mem_we      = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wdata   = rd_byte | (8'h01 << bit_ff);
      point_done  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = FILL_MASK;
         end
         ST_PT_RD: begin
            // out of range points are skipped without a ram access
            mem_rd_en  = pt_in_range;
            point_done = !pt_in_range;
         end
         ST_RMW_WR: begin
            // the next read comes in the cycle after the write, so no forwarding is needed
            mem_we     = 1'b1;
            point_done = 1'b1;
         end
         ST_SCAN: begin
            mem_rd_en   = !scan_cnt_ff[3];
            mem_rd_addr = {layer_ff, scan_cnt_ff[2:0]};
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // voxel ram, one write and one registered read per cycle
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wr_addr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         rdata_ff    <= store_mem[mem_rd_addr];
         rd_valid_ff <= valid_ff[mem_rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         edge_step_ff  <= '0;
         edge_index_ff <= '0;
         scan_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // clear drops every entry flag at once
         if (req_xfer && (req_kind == REQ_CLEAR)) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[mem_wr_addr] <= 1'b1;
         end

         // wire cube walk: edges inner, steps outer
         if (req_xfer) begin
            edge_step_ff  <= '0;
            edge_index_ff <= '0;
         end else if (point_done) begin
            if (last_point) begin
               edge_step_ff  <= '0;
               edge_index_ff <= '0;
            end else if (edge_index_ff == 4'(EDGE_COUNT - 1)) begin
               edge_index_ff <= '0;
               edge_step_ff  <= edge_step_ff + 5'd1;
            end else begin
               edge_index_ff <= edge_index_ff + 4'd1;
            end
         end

         if (req_xfer) begin
            scan_cnt_ff <= '0;
         end else if (state_ff == ST_SCAN) begin
            scan_cnt_ff <= scan_cnt_ff + 4'd1;
         end

         if (state_ff == ST_SCAN_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pos_x_ff    <= req_tdata[4:0];
         pos_y_ff    <= req_tdata[9:5];
         pos_z_ff    <= req_tdata[14:10];
         edge_len_ff <= req_tdata[19:15];
         layer_ff    <= req_tdata[22:20];
         cube_ff     <= (req_kind == REQ_CUBE);
         addr_ff     <= '0;
      end else begin
         case (state_ff)
            ST_FILL: begin
               // row first, then layer, over the SIDE x SIDE rows in range
               if (addr_ff[2:0] == 3'(SIDE - 1)) begin
                  addr_ff[2:0] <= '0;
                  addr_ff[5:3] <= addr_ff[5:3] + 3'd1;
               end else begin
                  addr_ff[2:0] <= addr_ff[2:0] + 3'd1;
               end
            end
            ST_PT_RD: begin
               addr_ff <= pt_addr;
               bit_ff  <= pt_x[2:0];
            end
            default: begin
            end
         endcase
      end

      // read data lands in the cycle after each scan read, row 0 ends lowest
      if (state_ff == ST_SCAN && scan_cnt_ff != 4'd0) begin
         scan_bits_ff <= {rd_byte, scan_bits_ff[63:8]};
      end

      if (state_ff == ST_SCAN_OUT && rsp_free) begin
         rsp_data_ff <= {scan_bits_ff, 8'(8'h80 >> layer_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/vcfb_checker.sv */
// ----------------------------------------------------------------------------
// vcfb_checker
// port level checks of the voxel cube frame buffer
// ----------------------------------------------------------------------------
`include "voxel_cube_frame_buffer_defines.svh"

module vcfb_checker
   import vcfb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   logic scan_xfer;
   logic other_xfer;

   assign scan_xfer  = req_tvalid && req_tready && (req_tuser == REQ_SCAN);
   assign other_xfer = req_tvalid && req_tready && (req_tuser != REQ_SCAN);

   // a stalled result holds
   `VCFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // layer select of a valid result is always one-hot
   `VCFB_ASSERT_SAME(a_select_onehot, clock, reset, rsp_tvalid, $onehot(rsp_tdata[7:0]), "layer select not one-hot")

   // a scan walks the ram, so the block is busy the next cycle
   `VCFB_ASSERT_NEXT(a_scan_busy, clock, reset, scan_xfer, !req_tready && !$rose(rsp_tvalid), "scan finished too early")

   // only a scan makes a result
   `VCFB_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, other_xfer, !$rose(rsp_tvalid), "result without a scan")

endmodule

bind voxel_cube_frame_buffer vcfb_checker u_vcfb_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the led cube frame buffer: a directed table of
// requests, then a long random mix of draws and layer scans, each layer scan
// checked against a hand-typed answer or a shadow copy of the 8x8x8 voxel store kept here
// ----------------------------------------------------------------------------
module tb_top;
   import vcfb_pkg::*;

   localparam int SIDE            = 8;
   localparam int RANDOM_ITEMS    = 1625;
   localparam int HOLD_OFF_CYCLES = 400;
   // longest wire cube here: the clipped one at the end of the directed table
   localparam int DRAIN_CYCLES    = 1000;
   // request kind outside the decoded set, dropped by the block
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   // one request as the bench sees it, plus an optional hand-typed scan
   typedef struct {
      logic [7:0]  sel;
      logic [63:0] bits;
   } layer_scan_type;

   typedef struct {
      logic [2:0]        kind;
      logic signed [4:0] pos_x;
      logic signed [4:0] pos_y;
      logic signed [4:0] pos_z;
      logic [4:0]        edge_len;
      logic [2:0]        layer;
      bit                typed;
      layer_scan_type    want;
   } voxel_req_type;

   typedef enum int {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_HICCUP
   } sink_mode_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // block ports, inputs all known from time zero
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // pos_x, pos_y, pos_z, edge_len, layer, zero pad
   logic [2:0]  req_tuser  = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // layer_select, layer_bits

   voxel_cube_frame_buffer #(
      .SIDE (SIDE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow of the voxel store, index 8*z+y, bit x
   logic [7:0]     shadow_store [64];
   layer_scan_type pending_scans [$];
   int             error_count = 0;

   // sender pacing
   int burst_left = 0;
   int gap_left   = 0;

   // long receiver hold-off, requested once by the stimulus
   bit hold_off_go   = 1'b0;
   bit hold_off_done = 1'b0;

   voxel_req_type directed_rows [$];

   // ------------------------------------------------------------------------
   // shadow store update
   // ------------------------------------------------------------------------

   // a voxel outside the cube is dropped, axis by axis
   function automatic void light_voxel(input int x, input int y, input int z);
      if (x < 0 || x >= SIDE || y < 0 || y >= SIDE || z < 0 || z >= SIDE)
         return;
      shadow_store[(z * 8 + y) & 63][x & 7] = 1'b1;
   endfunction

   // one point of the wireframe: step i along edge e, far corner at f
   function automatic void light_edge_point(input int x, input int y, input int z,
                                            input int f, input int i, input int e);
      case (e)
         0:       light_voxel(x,     y + i, z);
         1:       light_voxel(x + i, y,     z);
         2:       light_voxel(x,     y,     z + i);
         3:       light_voxel(x + f, y + i, z + f);
         4:       light_voxel(x + i, y + f, z + f);
         5:       light_voxel(x + f, y + f, z + i);
         6:       light_voxel(x + f, y + i, z);
         7:       light_voxel(x,     y + i, z + f);
         8:       light_voxel(x + i, y + f, z);
         9:       light_voxel(x + i, y,     z + f);
         10:      light_voxel(x + f, y,     z + i);
         default: light_voxel(x,     y + f, z + i);
      endcase
   endfunction

   // applies one accepted request, returns 1 with the scan it should give
   function automatic bit apply_to_shadow(input voxel_req_type r,
                                          output layer_scan_type scan);
      int x;
      int y;
      int z;
      int len;
      bit has_scan;
      x        = r.pos_x;
      y        = r.pos_y;
      z        = r.pos_z;
      len      = r.edge_len;
      has_scan = 1'b0;
      scan     = '{sel: '0, bits: '0};
      case (r.kind)
         REQ_CLEAR: begin
            foreach (shadow_store[k]) shadow_store[k] = 8'h00;
         end
         REQ_FILL: begin
            for (int zz = 0; zz < SIDE; zz++)
               for (int yy = 0; yy < SIDE; yy++)
                  shadow_store[(zz * 8 + yy) & 63] = 8'hff >> (8 - SIDE);
         end
         REQ_SET: begin
            light_voxel(x, y, z);
         end
         REQ_CUBE: begin
            for (int i = 0; i < len; i++)
               for (int e = 0; e < EDGE_COUNT; e++)
                  light_edge_point(x, y, z, len - 1, i, e);
         end
         REQ_SCAN: begin
            for (int yy = 0; yy < 8; yy++)
               scan.bits[8 * yy +: 8] = shadow_store[(r.layer * 8 + yy) & 63];
            scan.sel = 8'h80 >> r.layer;
            has_scan = 1'b1;
         end
         default: ;
      endcase
      return has_scan;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   function automatic voxel_req_type make_req(input logic [2:0] kind, input int x, input int y,
                                              input int z, input int len, input int lay,
                                              input bit typed = 1'b0,
                                              input logic [7:0] sel = '0,
                                              input logic [63:0] bits = '0);
      voxel_req_type r;
      r.kind      = kind;
      r.pos_x     = x[4:0];
      r.pos_y     = y[4:0];
      r.pos_z     = z[4:0];
      r.edge_len  = len[4:0];
      r.layer     = lay[2:0];
      r.typed     = typed;
      r.want.sel  = sel;
      r.want.bits = bits;
      return r;
   endfunction

   // uniform coordinate in lo..hi, wrapped to the 5-bit field
   function automatic logic [4:0] pick_coord(input int lo, input int hi);
      int v;
      v = int'($urandom_range(hi - lo, 0)) + lo;
      return v[4:0];
   endfunction

   // random mix: mostly scans, in-cube voxels and small cubes, with some noise
   function automatic voxel_req_type random_req();
      voxel_req_type r;
      int pick;
      pick       = $urandom_range(99, 0);
      r          = make_req(REQ_SCAN, 0, 0, 0, 0, 0);
      r.pos_x    = 5'($urandom_range(31, 0));
      r.pos_y    = 5'($urandom_range(31, 0));
      r.pos_z    = 5'($urandom_range(31, 0));
      r.edge_len = 5'($urandom_range(16, 0));
      r.layer    = 3'($urandom_range(7, 0));
      if (pick < 30 || pick >= 92) begin
         r.kind = REQ_SCAN;
      end else if (pick < 60) begin
         r.kind = REQ_SET;
         // mostly inside, the rest keeps the full signed range
         if ($urandom_range(99, 0) < 85) begin
            r.pos_x = pick_coord(0, SIDE - 1);
            r.pos_y = pick_coord(0, SIDE - 1);
            r.pos_z = pick_coord(0, SIDE - 1);
         end
      end else if (pick < 80) begin
         r.kind = REQ_CUBE;
         if ($urandom_range(99, 0) < 75) begin
            r.edge_len = 5'($urandom_range(6, 1));
            r.pos_x    = pick_coord(-3, SIDE);
            r.pos_y    = pick_coord(-3, SIDE);
            r.pos_z    = pick_coord(-3, SIDE);
         end
      end else if (pick < 84) begin
         r.kind = REQ_CLEAR;
      end else if (pick < 88) begin
         r.kind = REQ_FILL;
      end else begin
         r.kind = 3'($urandom_range(REQ_UNUSED, int'(REQ_SCAN) + 1));
      end
      return r;
   endfunction

   // offers one request, waits for its transfer and records what it should give
   task automatic offer_request(input voxel_req_type r);
      layer_scan_type scan;
      bit             has_scan;
      // gap only when one is due, so valid is never dropped and raised in one step
      if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_left) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {1'b0, r.layer, r.edge_len, r.pos_z, r.pos_y, r.pos_x};
      do @(posedge clock); while (!req_tready);
      // transfer on this edge
      has_scan = apply_to_shadow(r, scan);
      if (has_scan)
         pending_scans.push_back(r.typed ? r.want : scan);
      if (burst_left > 0) begin
         burst_left--;
         gap_left = 0;
      end else begin
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 40)
                                                  : $urandom_range(12, 0);
         gap_left   = $urandom_range(8, 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int random_count;
      random_count = 0;
      foreach (shadow_store[k]) shadow_store[k] = 8'h00;

      // directed table: typed scans where the answer is obvious
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 0, 1'b1, 8'h80, 64'h0));
      directed_rows.push_back(make_req(REQ_SCAN,   15, 15, 15, 16, 7, 1'b1, 8'h01, 64'h0));
      directed_rows.push_back(make_req(REQ_FILL,    0,  0,  0,  0, 0));
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 3, 1'b1, 8'h10, '1));
      // unknown kind, must leave no result and no trace
      directed_rows.push_back(make_req(REQ_UNUSED,  3,  3,  3,  4, 2));
      directed_rows.push_back(make_req(REQ_CLEAR,  -1, -1, -1, 16, 7));
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 5, 1'b1, 8'h04, 64'h0));
      // opposite corners, then points off the cube on each axis
      directed_rows.push_back(make_req(REQ_SET,     0,  0,  0,  0, 0));
      directed_rows.push_back(make_req(REQ_SET,     7,  7,  7,  0, 0));
      directed_rows.push_back(make_req(REQ_SET,   -16,  0,  0,  0, 0));
      directed_rows.push_back(make_req(REQ_SET,    15,  3,  3,  0, 0));
      directed_rows.push_back(make_req(REQ_SET,     3, -1,  3,  0, 0));
      directed_rows.push_back(make_req(REQ_SET,     3,  3,  8,  0, 0));
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 0, 1'b1, 8'h80, 64'h1));
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 7, 1'b1, 8'h01,
                                       64'h8000_0000_0000_0000));
      // full-size wireframe, then a clipped one larger than the cube
      directed_rows.push_back(make_req(REQ_CUBE,    0,  0,  0,  8, 0));
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 0));
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 4));
      directed_rows.push_back(make_req(REQ_CLEAR,   0,  0,  0,  0, 0));
      directed_rows.push_back(make_req(REQ_CUBE,   -3, -3, -3, 16, 0));
      directed_rows.push_back(make_req(REQ_SCAN,    0,  0,  0,  0, 6));
      // zero edge draws nothing, a corner far off draws nothing
      directed_rows.push_back(make_req(REQ_CUBE,    2,  2,  2,  0, 0));
      directed_rows.push_back(make_req(REQ_CUBE,   15, 15, 15,  1, 0));
      // edge length past sixteen, far edges clipped away
      directed_rows.push_back(make_req(REQ_CUBE,    2,  2,  2, 20, 0));
      directed_rows.push_back(make_req(REQ_SCAN,  -16,-16,-16, 16, 2));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         offer_request(directed_rows[n]);

      // receiver goes quiet for a while so the block backs up into its input
      hold_off_go = 1'b1;
      while (random_count < RANDOM_ITEMS) begin
         voxel_req_type r;
         r = random_req();
         offer_request(r);
         random_count++;
      end
      req_tvalid <= 1'b0;

      // drain outstanding scans, then a quiet tail to catch strays
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: stall pattern of its own plus the single long hold-off
   // ------------------------------------------------------------------------
   initial begin : result_sink
      sink_mode_type mode;
      int            phase;
      mode  = SINK_OPEN;
      phase = 0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            phase++;
            if (phase % 128 == 0)
               mode = sink_mode_type'($urandom_range(int'(SINK_HICCUP), int'(SINK_OPEN)));
            case (mode)
               SINK_OPEN:   rsp_tready <= 1'b1;
               SINK_COIN:   rsp_tready <= 1'($urandom_range(1, 0));
               SINK_SPARSE: rsp_tready <= (phase % 4 == 0);
               default:     rsp_tready <= (phase % 8 != 7);
            endcase
         end
      end
   end

   // compare every result transfer with the oldest outstanding scan
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scans.size() == 0) begin
            $error("result transfer with none outstanding: layer_select %h layer_bits %h",
                   rsp_tdata[7:0], rsp_tdata[71:8]);
            error_count++;
         end else begin
            layer_scan_type want;
            want = pending_scans.pop_front();
            if (rsp_tdata[7:0] !== want.sel) begin
               $error("layer_select: expected %h, actual %h", want.sel, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[71:8] !== want.bits) begin
               $error("layer_bits: expected %h, actual %h", want.bits, rsp_tdata[71:8]);
               error_count++;
            end
         end
      end
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #(30_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/vcfb_pkg.sv
rtl/core/voxel_cube_frame_buffer.sv
rtl/core/vcfb_checker.sv
verif/tb_top.sv
